// ===== hdl/lspp_pkg.sv =====
// Package for the scan packet parser: frame constants, angle constants and
// the status and write structs of the frame queue. No dependencies.
`default_nettype none

package lspp_pkg;

	// Frame format.
	localparam int POINTS_PER_FRAME = 12;
	localparam int HDR_LEN          = 11;
	localparam int BYTES_PER_POINT  = 3;
	localparam int START_OFF        = 4;
	localparam int FIRST_PT_OFF     = 6;
	localparam logic [7:0] HDR0     = 8'h54;
	localparam logic [7:0] HDR1     = 8'h2C;

	// Angle arithmetic: x / 100 == (x * DIV100_RECIP) >> DIV100_SHIFT for 16-bit x.
	localparam int CDEG_PER_DEG   = 100;
	localparam int FULL_DEG       = 360;
	localparam int TURN_CDEG      = 36000;
	localparam int DIV100_RECIP   = 167773;
	localparam int DIV100_SHIFT   = 24;

	// Result field widths.
	localparam int ANGLE_W = 16;
	localparam int DIST_W  = 16;
	localparam int QUAL_W  = 8;
	localparam int INDEX_W = 4;

	// Frame queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic push;
		logic bank;
	} qwr_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic              head_bank;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

`default_nettype wire

// ===== hdl/lspp_front.sv =====
// Front part of the scan packet parser: counts bytes into frames, checks the
// header and owns the two-bank frame memory. Depends on lspp_pkg.
`default_nettype none

module lspp_front #(
	parameter int POINTS_PER_FRAME = lspp_pkg::POINTS_PER_FRAME
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic [7:0]           rx_byte,
	output logic                      full,
	input  wire lspp_pkg::qstat_t     qstat,
	output lspp_pkg::qwr_t            qwr,
	input  wire logic                 rd_bank,
	input  wire logic [$clog2(11 + 3 * POINTS_PER_FRAME)-1:0] rd_off,
	output logic [7:0]                rd_data
);

	localparam int FRAME_LEN = lspp_pkg::HDR_LEN + lspp_pkg::BYTES_PER_POINT * POINTS_PER_FRAME;
	localparam int OFF_W     = $clog2(FRAME_LEN);
	localparam int MEM_DEPTH = 2 ** (OFF_W + 1);

	logic [OFF_W-1:0] off_q;
	logic             bank_q;
	logic             h0_q;
	logic             h1_q;
	logic             accept;
	logic             closing;
	logic [7:0]       mem_q [MEM_DEPTH];

	// A byte transaction completes when there is room for a new frame.
	assign full    = qstat.full;
	assign accept  = push && !qstat.full;
	assign closing = (off_q == OFF_W'(FRAME_LEN - 1));

	// A closing byte of a frame with a good header hands its bank to the back.
	assign qwr.push = accept && closing && h0_q && h1_q;
	assign qwr.bank = bank_q;

	// Byte counter and bank select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (closing) begin
				off_q <= '0;
				if (h0_q && h1_q) begin
					bank_q <= ~bank_q;
				end
			end else begin
				off_q <= off_q + OFF_W'(1);
			end
		end
	end

	// Header flags, captured as the first two bytes arrive.
	always_ff @(posedge clk) begin
		if (accept && off_q == OFF_W'(0)) begin
			h0_q <= (rx_byte == lspp_pkg::HDR0);
		end
		if (accept && off_q == OFF_W'(1)) begin
			h1_q <= (rx_byte == lspp_pkg::HDR1);
		end
	end

	// Frame memory: written by the front, read by the back with registered data.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[{bank_q, off_q}] <= rx_byte;
		end
		rd_data <= mem_q[{rd_bank, rd_off}];
	end

endmodule

`default_nettype wire

// ===== hdl/lspp_fifo.sv =====
// Short queue of frame banks waiting for the back part of the parser.
// Depends on lspp_pkg.
`default_nettype none

module lspp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lspp_pkg::qwr_t   qwr,
	input  wire logic             pop,
	output lspp_pkg::qstat_t      qstat
);

	localparam int QD = lspp_pkg::QDEPTH;
	localparam int PW = lspp_pkg::QPTR_W;
	localparam int CW = lspp_pkg::QCNT_W;

	logic          bank_q [QD];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign do_push = qwr.push && (count_q != CW'(QD));
	assign do_pop  = pop && (count_q != CW'(0));

	assign qstat.empty     = (count_q == CW'(0));
	assign qstat.full      = (count_q == CW'(QD));
	assign qstat.head_bank = bank_q[rd_ptr_q];
	assign qstat.count     = count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			bank_q[wr_ptr_q] <= qwr.bank;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lspp_back.sv =====
// Back part of the scan packet parser: reads a queued frame, works out the
// angle sweep with a reciprocal multiplication and emits the points. Depends on lspp_pkg.
`default_nettype none

module lspp_back #(
	parameter int POINTS_PER_FRAME = lspp_pkg::POINTS_PER_FRAME
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lspp_pkg::qstat_t     qstat,
	output logic                      pop_frame,
	output logic                      rd_bank,
	output logic [$clog2(11 + 3 * POINTS_PER_FRAME)-1:0] rd_off,
	input  wire logic [7:0]           rd_data,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [lspp_pkg::ANGLE_W-1:0] angle_centideg,
	output logic [lspp_pkg::DIST_W-1:0]  distance_mm,
	output logic [lspp_pkg::QUAL_W-1:0]  quality,
	output logic [lspp_pkg::INDEX_W-1:0] point_index,
	output logic                      last_point
);

	localparam int FRAME_LEN = lspp_pkg::HDR_LEN + lspp_pkg::BYTES_PER_POINT * POINTS_PER_FRAME;
	localparam int OFF_W     = $clog2(FRAME_LEN);
	localparam int END_OFF   = lspp_pkg::FIRST_PT_OFF + lspp_pkg::BYTES_PER_POINT * POINTS_PER_FRAME;
	localparam int DEN       = POINTS_PER_FRAME - 1;
	localparam int DEN_W     = $clog2(DEN + 1);
	localparam int NW        = DEN_W + 17;
	localparam int IDX_W     = $clog2(POINTS_PER_FRAME);
	localparam int PROD_W    = 34;
	localparam int DEG_W     = 10;
	localparam int AW        = 19;
	// Reciprocal of the point step divisor: exact floor for any NW-bit dividend.
	localparam int     RK    = NW + DEN_W;
	localparam int     RP_W  = NW + RK;
	localparam longint RM    = ((longint'(1) << RK) + longint'(DEN) - 1) / longint'(DEN);

	localparam logic signed [AW-1:0] TurnS  = AW'(lspp_pkg::TURN_CDEG);
	localparam logic signed [AW-1:0] CdegS  = AW'(lspp_pkg::CDEG_PER_DEG);
	localparam logic signed [11:0]   FullS  = 12'(lspp_pkg::FULL_DEG);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_ST_LO = 16'h0002,
		S_ST_HI = 16'h0004,
		S_EN_LO = 16'h0008,
		S_EN_HI = 16'h0010,
		S_MUL_S = 16'h0020,
		S_MUL_E = 16'h0040,
		S_SPAN  = 16'h0080,
		S_DIV   = 16'h0100,
		S_REM   = 16'h0200,
		S_P0    = 16'h0400,
		S_P1    = 16'h0800,
		S_P2    = 16'h1000,
		S_P3    = 16'h2000,
		S_WRAP  = 16'h4000,
		S_EMIT  = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [7:0]              tmp_q;
	logic [15:0]             start_q;
	logic [15:0]             end_q;
	logic [DEG_W-1:0]        s_deg_q;
	logic [DEG_W-1:0]        e_deg_q;
	logic [15:0]             base_q;
	logic [NW-1:0]           num_q;
	logic [NW-1:0]           quo_q;
	logic [DEN_W-1:0]        rem_q;
	logic signed [AW-1:0]    q_acc_q;
	logic [DEN_W-1:0]        r_acc_q;
	logic [IDX_W-1:0]        idx_q;
	logic [OFF_W-1:0]        off_q;
	logic [7:0]              dlo_q;
	logic [15:0]             dist_q;
	logic [7:0]              qual_q;
	logic signed [AW-1:0]    ang_q;
	logic                    out_valid_q;

	logic [15:0]             mul_in;
	logic [PROD_W-1:0]       prod;
	logic signed [11:0]      span_raw;
	logic signed [11:0]      span_adj;
	logic signed [AW-1:0]    step_w;
	logic [NW-1:0]           num_w;
	logic [RP_W-1:0]         rprod;
	logic [NW-1:0]           rem_w;
	logic signed [AW-1:0]    qstep;
	logic [DEN_W:0]          r_sum;
	logic                    r_carry;
	logic                    is_last;
	logic                    out_free;
	logic                    emit;

	// Shared reciprocal multiplier for the whole-degree truncation.
	assign mul_in = (state_q == S_MUL_S) ? start_q : end_q;
	assign prod   = PROD_W'(mul_in) * PROD_W'(lspp_pkg::DIV100_RECIP);

	// Sweep span in degrees, wrapped once, and its value in hundredths.
	assign span_raw = $signed({2'b00, e_deg_q}) - $signed({2'b00, s_deg_q});
	assign span_adj = (span_raw < 0) ? span_raw + FullS : span_raw;
	assign step_w   = AW'(span_adj) * CdegS;
	// Offset by DEN * 2^16 so the division sees a non-negative dividend.
	assign num_w    = NW'(step_w) + (NW'(DEN) << 16);

	// Quotient by reciprocal multiplication, remainder in the cycle after, from the registered quotient.
	assign rprod    = RP_W'(num_q) * RP_W'(RM);
	assign rem_w    = num_q - quo_q * NW'(DEN);

	// Floor quotient per point step, with the dividend offset removed.
	assign qstep    = $signed(AW'(quo_q - (NW'(1) << 16)));
	assign r_sum    = {1'b0, r_acc_q} + {1'b0, rem_q};
	assign r_carry  = (r_sum >= (DEN_W + 1)'(DEN));

	assign is_last  = (idx_q == IDX_W'(POINTS_PER_FRAME - 1));
	assign out_free = !out_valid_q || pop;
	assign rd_bank  = qstat.head_bank;

	// Sequencer: next state, memory read offset and frame release.
	always_comb begin
		state_d   = state_q;
		rd_off    = '0;
		pop_frame = 1'b0;
		emit      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (!qstat.empty) begin
					state_d = S_ST_LO;
				end
			end
			S_ST_LO: begin
				rd_off  = OFF_W'(lspp_pkg::START_OFF);
				state_d = S_ST_HI;
			end
			S_ST_HI: begin
				rd_off  = OFF_W'(lspp_pkg::START_OFF + 1);
				state_d = S_EN_LO;
			end
			S_EN_LO: begin
				rd_off  = OFF_W'(END_OFF);
				state_d = S_EN_HI;
			end
			S_EN_HI: begin
				rd_off  = OFF_W'(END_OFF + 1);
				state_d = S_MUL_S;
			end
			S_MUL_S: state_d = S_MUL_E;
			S_MUL_E: state_d = S_SPAN;
			S_SPAN:  state_d = S_DIV;
			S_DIV:   state_d = S_REM;
			S_REM:   state_d = S_P0;
			S_P0: begin
				rd_off  = off_q;
				state_d = S_P1;
			end
			S_P1: begin
				rd_off  = off_q + OFF_W'(1);
				state_d = S_P2;
			end
			S_P2: begin
				rd_off  = off_q + OFF_W'(2);
				state_d = S_P3;
			end
			S_P3: state_d = S_WRAP;
			S_WRAP: begin
				if (ang_q >= 0 && ang_q < TurnS) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (is_last) begin
						pop_frame = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_P0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, loaded as the sequencer passes through its states.
	always_ff @(posedge clk) begin
		case (state_q)
			S_ST_HI: tmp_q   <= rd_data;
			S_EN_LO: start_q <= {rd_data, tmp_q};
			S_EN_HI: tmp_q   <= rd_data;
			S_MUL_S: begin
				end_q   <= {rd_data, tmp_q};
				s_deg_q <= prod[lspp_pkg::DIV100_SHIFT +: DEG_W];
			end
			S_MUL_E: e_deg_q <= prod[lspp_pkg::DIV100_SHIFT +: DEG_W];
			S_SPAN: begin
				num_q  <= num_w;
				base_q <= 16'(17'(s_deg_q) * 17'(lspp_pkg::CDEG_PER_DEG));
			end
			S_DIV: quo_q <= rprod[RK +: NW];
			S_REM: begin
				rem_q   <= rem_w[DEN_W-1:0];
				q_acc_q <= '0;
				r_acc_q <= '0;
				idx_q   <= '0;
				off_q   <= OFF_W'(lspp_pkg::FIRST_PT_OFF);
			end
			S_P1: dlo_q  <= rd_data;
			S_P2: dist_q <= {rd_data, dlo_q};
			S_P3: begin
				qual_q <= rd_data;
				ang_q  <= $signed({3'b000, base_q}) + q_acc_q;
			end
			S_WRAP: begin
				if (ang_q < 0) begin
					ang_q <= ang_q + TurnS;
				end else if (ang_q >= TurnS) begin
					ang_q <= ang_q - TurnS;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					if (r_carry) begin
						r_acc_q <= DEN_W'(r_sum - (DEN_W + 1)'(DEN));
						q_acc_q <= q_acc_q + qstep + AW'(1);
					end else begin
						r_acc_q <= r_sum[DEN_W-1:0];
						q_acc_q <= q_acc_q + qstep;
					end
					idx_q <= idx_q + IDX_W'(1);
					off_q <= off_q + OFF_W'(lspp_pkg::BYTES_PER_POINT);
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (emit) begin
			angle_centideg <= ang_q[lspp_pkg::ANGLE_W-1:0];
			distance_mm    <= dist_q;
			quality        <= qual_q;
			point_index    <= lspp_pkg::INDEX_W'(idx_q);
			last_point     <= is_last;
		end
	end

	assign empty = !out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/lidar_scan_packet_parser.sv =====
// Top level of the scan packet parser: front, frame queue and back.
// Depends on lspp_pkg, lspp_front, lspp_fifo and lspp_back.
`default_nettype none

// The parser takes one byte per cycle while full is low and cuts the stream into
// fixed frames of 11 + 3 * POINTS_PER_FRAME bytes with no resynchronization. A
// frame that starts with 0x54 0x2C yields POINTS_PER_FRAME point results; any
// other frame is dropped. The frame memory has two banks, so full rises only
// after two good frames wait for the back part, and then only until the older
// one is done. After its closing byte a frame goes through setup: four reads for
// the start and end angles, two reciprocal multiplications for whole degrees,
// the span, and the reciprocal division of the angle step with its remainder.
// Then each point takes three reads of the single memory read port, wrap steps
// into one turn and the output load, held back while a result waits for pop.
// The memory needs no clearing pass: every entry is written before it is read.

module lidar_scan_packet_parser #(
	parameter int POINTS_PER_FRAME = lspp_pkg::POINTS_PER_FRAME
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [7:0]                  rx_byte,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [lspp_pkg::ANGLE_W-1:0]     angle_centideg,
	output logic [lspp_pkg::DIST_W-1:0]      distance_mm,
	output logic [lspp_pkg::QUAL_W-1:0]      quality,
	output logic [lspp_pkg::INDEX_W-1:0]     point_index,
	output logic                             last_point
);

	localparam int FRAME_LEN = lspp_pkg::HDR_LEN + lspp_pkg::BYTES_PER_POINT * POINTS_PER_FRAME;
	localparam int OFF_W     = $clog2(FRAME_LEN);

	lspp_pkg::qstat_t qstat;
	lspp_pkg::qwr_t   qwr;
	logic             pop_frame;
	logic             rd_bank;
	logic [OFF_W-1:0] rd_off;
	logic [7:0]       rd_data;

	lspp_front #(
		.POINTS_PER_FRAME(POINTS_PER_FRAME)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.qstat   (qstat),
		.qwr     (qwr),
		.rd_bank (rd_bank),
		.rd_off  (rd_off),
		.rd_data (rd_data)
	);

	lspp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.pop    (pop_frame),
		.qstat  (qstat)
	);

	lspp_back #(
		.POINTS_PER_FRAME(POINTS_PER_FRAME)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.pop_frame      (pop_frame),
		.rd_bank        (rd_bank),
		.rd_off         (rd_off),
		.rd_data        (rd_data),
		.empty          (empty),
		.pop            (pop),
		.angle_centideg (angle_centideg),
		.distance_mm    (distance_mm),
		.quality        (quality),
		.point_index    (point_index),
		.last_point     (last_point)
	);

	// A waiting result always carries a wrapped angle.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> angle_centideg < lspp_pkg::ANGLE_W'(lspp_pkg::TURN_CDEG))
		else $error("angle out of range");

	// The closing point of a frame carries the last index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_point) |->
			point_index == lspp_pkg::INDEX_W'(POINTS_PER_FRAME - 1))
		else $error("last point with wrong index");

	// The frame queue never holds more frames than there are banks.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= lspp_pkg::QCNT_W'(lspp_pkg::QDEPTH))
		else $error("frame queue overflow");

	// A frame is released only while one is queued.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		pop_frame |-> !qstat.empty)
		else $error("frame released from empty queue");

endmodule

`default_nettype wire
